@@ sv/bpc_pkg.sv @@
package bpc_pkg;

  localparam int DIV_STAGES = 32;
  localparam int NUM_STAGES = 14 + 2 * DIV_STAGES;

  localparam logic [2:0] REG_AC1   = 3'd0;
  localparam logic [2:0] REG_AC2   = 3'd1;
  localparam logic [2:0] REG_AC3   = 3'd2;
  localparam logic [2:0] REG_AC4   = 3'd3;
  localparam logic [2:0] REG_AC5   = 3'd4;
  localparam logic [2:0] REG_AC6   = 3'd5;
  localparam logic [2:0] REG_B1_B2 = 3'd6;
  localparam logic [2:0] REG_MC_MD = 3'd7;

  localparam logic [15:0] RST_AC1   = 16'd408;
  localparam logic [15:0] RST_AC2   = 16'hFFB8;
  localparam logic [15:0] RST_AC3   = 16'hC7D1;
  localparam logic [15:0] RST_AC4   = 16'd32741;
  localparam logic [15:0] RST_AC5   = 16'd32757;
  localparam logic [15:0] RST_AC6   = 16'd23153;
  localparam logic [31:0] RST_B1_B2 = 32'd405667844;
  localparam logic [31:0] RST_MC_MD = 32'd3724086068;

  localparam logic [31:0] K_B6_OFS  = 32'd4000;
  localparam logic [31:0] K_X3_OFS  = 32'd32768;
  localparam logic [31:0] K_B7_MUL  = 32'd50000;
  localparam logic [31:0] K_P_MUL1  = 32'd3038;
  localparam logic [31:0] K_P_MUL2  = 32'hFFFF_E343;
  localparam logic [31:0] K_P_OFS   = 32'd3791;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(logic [31:0] v, int unsigned n);
    return 32'($signed(v) >>> n);
  endfunction

endpackage

@@ sv/bpc_div.sv @@
module bpc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);
  import bpc_pkg::*;

  logic [31:0] rem_q [1:DIV_STAGES];
  logic [31:0] num_q [1:DIV_STAGES];
  logic [31:0] den_q [1:DIV_STAGES];
  logic [31:0] quo_q [1:DIV_STAGES];

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    logic [31:0] rp, np, dp, qp;
    logic [32:0] trial;
    logic        ge;
    if (k == 1) begin : g_first
      assign rp = '0;
      assign np = num;
      assign dp = den;
      assign qp = '0;
    end else begin : g_rest
      assign rp = rem_q[k-1];
      assign np = num_q[k-1];
      assign dp = den_q[k-1];
      assign qp = quo_q[k-1];
    end
    assign trial = {rp, np[31]};
    assign ge    = trial >= {1'b0, dp};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? 32'(trial - {1'b0, dp}) : trial[31:0];
        num_q[k] <= {np[30:0], 1'b0};
        den_q[k] <= dp;
        quo_q[k] <= {qp[30:0], ge};
      end
    end
  end

  assign quo = quo_q[DIV_STAGES];

endmodule

@@ sv/barometric_pressure_compensation_top.sv @@
// Barometric sensor compensation.
// Input stream: s_tdata carries one raw temperature and one raw pressure
// reading; a transaction takes place when s_tvalid and s_tready are high.
// Output stream: m_tdata carries compensated temperature (0.1 C) and
// pressure (Pa); m_tuser is the fault flag, set when a divisor was zero,
// in which case both results are zero.
// Coefficients are to be written through cfg_we/cfg_addr/cfg_data while
// idle; the user is bound by this, the block itself does not enforce it.
// Two 32-stage bit-per-stage dividers plus 14 arithmetic stages form the
// pipeline. Throughput: one transaction per cycle unless the output stalls.
// Reset clears all valid bits and loads the default coefficients.
// When the receiver stalls, the whole pipeline holds and s_tready drops;
// nothing is lost or repeated.
module barometric_pressure_compensation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // raw_temp[15:0], raw_press[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // temp_tenths[31:0], press_pa[63:32]
  output logic        m_tuser,   // fault
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data
);
  import bpc_pkg::*;

  logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6;
  logic [31:0] b1b2, mcmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1 <= RST_AC1; ac2 <= RST_AC2; ac3 <= RST_AC3;
      ac4 <= RST_AC4; ac5 <= RST_AC5; ac6 <= RST_AC6;
      b1b2 <= RST_B1_B2; mcmd <= RST_MC_MD;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_AC1:   ac1  <= cfg_data[15:0];
        REG_AC2:   ac2  <= cfg_data[15:0];
        REG_AC3:   ac3  <= cfg_data[15:0];
        REG_AC4:   ac4  <= cfg_data[15:0];
        REG_AC5:   ac5  <= cfg_data[15:0];
        REG_AC6:   ac6  <= cfg_data[15:0];
        REG_B1_B2: b1b2 <= cfg_data;
        REG_MC_MD: mcmd <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [31:0] c_ac1, c_ac2, c_ac3, c_b1, c_b2, c_mc, c_md;
  assign c_ac1 = sx16(ac1);
  assign c_ac2 = sx16(ac2);
  assign c_ac3 = sx16(ac3);
  assign c_b1  = sx16(b1b2[31:16]);
  assign c_b2  = sx16(b1b2[15:0]);
  assign c_mc  = sx16(mcmd[31:16]);
  assign c_md  = sx16(mcmd[15:0]);

  logic                  en;
  logic [NUM_STAGES-1:0] vld;

  assign en       = !vld[NUM_STAGES-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], s_tvalid};
    end
  end

  // S1
  logic [31:0] s1_t, s1_up;
  // S2
  logic [31:0] s2_num, s2_den, s2_x1, s2_up;
  logic        s2_neg, s2_flt;
  // divider A side path
  logic [31:0] da_x1 [0:DIV_STAGES-1];
  logic [31:0] da_up [0:DIV_STAGES-1];
  logic        da_neg [0:DIV_STAGES-1];
  logic        da_flt [0:DIV_STAGES-1];
  logic [31:0] qa;
  // S3..S10
  logic [31:0] s3_b5, s3_temp, s3_up;
  logic        s3_flt;
  logic [31:0] s4_b6, s4_temp, s4_up;
  logic        s4_flt;
  logic [31:0] s5_p66, s5_pa2, s5_pa3, s5_temp, s5_up;
  logic        s5_flt;
  logic [31:0] s6_pb2, s6_pb1, s6_x2a, s6_x1b, s6_temp, s6_up;
  logic        s6_flt;
  logic [31:0] s7_b3, s7_t, s7_temp, s7_up;
  logic        s7_flt;
  logic [31:0] s8_pb4, s8_d7, s8_temp;
  logic        s8_flt;
  logic [31:0] s9_b4, s9_b7, s9_temp;
  logic        s9_flt;
  logic [31:0] s10_num, s10_den, s10_temp;
  logic        s10_sh, s10_flt;
  // divider B side path
  logic [31:0] db_temp [0:DIV_STAGES-1];
  logic        db_sh   [0:DIV_STAGES-1];
  logic        db_flt  [0:DIV_STAGES-1];
  logic [31:0] qb;
  // S11..S14
  logic [31:0] s11_p, s11_temp;
  logic        s11_flt;
  logic [31:0] s12_m1, s12_x2, s12_p, s12_temp;
  logic        s12_flt;
  logic [31:0] s13_m2, s13_x2, s13_p, s13_temp;
  logic        s13_flt;
  logic [31:0] out_temp, out_press;
  logic        out_flt;

  logic [31:0] x1c, dvc, nmc, s3_q, s6_sq, s10_b7n, s11_q, s12_ps, s14_press;
  logic [31:0] s7_b3c, s7_x3c;

  assign x1c = asr(s1_t, 15);
  assign dvc = x1c + c_md;
  assign nmc = c_mc << 11;
  assign s3_q = da_neg[DIV_STAGES-1] ? 32'(-qa) : qa;
  assign s6_sq = asr(s5_p66, 12);
  assign s7_b3c = asr(32'(c_ac1 * 32'd4) + asr(s6_pb2, 11) + s6_x2a + 32'd2, 2);
  assign s7_x3c = asr(s6_x1b + asr(s6_pb1, 16) + 32'd2, 2);
  assign s10_b7n = s9_b7[31] ? s9_b7 : {s9_b7[30:0], 1'b0};
  assign s11_q = qb;
  assign s12_ps = asr(s11_p, 8);
  assign s14_press = s13_p + asr(asr(s13_m2, 16) + s13_x2 + K_P_OFS, 4);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t  <= 32'(({16'd0, s_tdata[15:0]} - {16'd0, ac6}) * {16'd0, ac5});
      s1_up <= {16'd0, s_tdata[31:16]};

      s2_num <= nmc[31] ? 32'(-nmc) : nmc;
      s2_den <= dvc[31] ? 32'(-dvc) : dvc;
      s2_neg <= nmc[31] ^ dvc[31];
      s2_flt <= (dvc == '0);
      s2_x1  <= x1c;
      s2_up  <= s1_up;

      da_x1[0] <= s2_x1; da_up[0] <= s2_up;
      da_neg[0] <= s2_neg; da_flt[0] <= s2_flt;
      for (int i = 1; i < DIV_STAGES; i++) begin
        da_x1[i] <= da_x1[i-1]; da_up[i] <= da_up[i-1];
        da_neg[i] <= da_neg[i-1]; da_flt[i] <= da_flt[i-1];
      end

      s3_b5   <= da_x1[DIV_STAGES-1] + s3_q;
      s3_temp <= asr(da_x1[DIV_STAGES-1] + s3_q + 32'd8, 4);
      s3_up   <= da_up[DIV_STAGES-1];
      s3_flt  <= da_flt[DIV_STAGES-1];

      s4_b6 <= s3_b5 - K_B6_OFS;
      s4_temp <= s3_temp; s4_up <= s3_up; s4_flt <= s3_flt;

      s5_p66 <= 32'(s4_b6 * s4_b6);
      s5_pa2 <= 32'(c_ac2 * s4_b6);
      s5_pa3 <= 32'(c_ac3 * s4_b6);
      s5_temp <= s4_temp; s5_up <= s4_up; s5_flt <= s4_flt;

      s6_pb2 <= 32'(c_b2 * s6_sq);
      s6_pb1 <= 32'(c_b1 * s6_sq);
      s6_x2a <= asr(s5_pa2, 11);
      s6_x1b <= asr(s5_pa3, 13);
      s6_temp <= s5_temp; s6_up <= s5_up; s6_flt <= s5_flt;

      s7_b3 <= s7_b3c;
      s7_t  <= s7_x3c + K_X3_OFS;
      s7_temp <= s6_temp; s7_up <= s6_up; s7_flt <= s6_flt;

      s8_pb4 <= 32'({16'd0, ac4} * s7_t);
      s8_d7  <= s7_up - s7_b3;
      s8_temp <= s7_temp; s8_flt <= s7_flt;

      s9_b4 <= s8_pb4 >> 15;
      s9_b7 <= 32'(s8_d7 * K_B7_MUL);
      s9_temp <= s8_temp; s9_flt <= s8_flt;

      s10_num <= s10_b7n;
      s10_den <= s9_b4;
      s10_sh  <= s9_b7[31];
      s10_flt <= s9_flt || (s9_b4 == '0);
      s10_temp <= s9_temp;

      db_temp[0] <= s10_temp; db_sh[0] <= s10_sh; db_flt[0] <= s10_flt;
      for (int i = 1; i < DIV_STAGES; i++) begin
        db_temp[i] <= db_temp[i-1]; db_sh[i] <= db_sh[i-1]; db_flt[i] <= db_flt[i-1];
      end

      s11_p <= db_sh[DIV_STAGES-1] ? {s11_q[30:0], 1'b0} : s11_q;
      s11_temp <= db_temp[DIV_STAGES-1];
      s11_flt  <= db_flt[DIV_STAGES-1];

      s12_m1 <= 32'(s12_ps * s12_ps);
      s12_x2 <= asr(32'(s11_p * K_P_MUL2), 16);
      s12_p <= s11_p; s12_temp <= s11_temp; s12_flt <= s11_flt;

      s13_m2 <= 32'(s12_m1 * K_P_MUL1);
      s13_x2 <= s12_x2; s13_p <= s12_p; s13_temp <= s12_temp; s13_flt <= s12_flt;

      out_temp  <= s13_flt ? '0 : s13_temp;
      out_press <= s13_flt ? '0 : s14_press;
      out_flt   <= s13_flt;
    end
  end

  bpc_div u_div_temp (
    .clk (clk),
    .en  (en),
    .num (s2_num),
    .den (s2_den),
    .quo (qa)
  );

  bpc_div u_div_press (
    .clk (clk),
    .en  (en),
    .num (s10_num),
    .den (s10_den),
    .quo (qb)
  );

  assign m_tdata = {out_press, out_temp};
  assign m_tuser = out_flt;

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready does not follow output stall");
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("fault result not zero");
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

@@ bench/barometric_pressure_compensation_top_test.sv @@
module barometric_pressure_compensation_top_test;
  import bpc_pkg::*;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic        fault;
  } reading_t;

  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [31:0] NEG_7357    = 32'hFFFF_E343;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  logic [31:0] coef [8];
  logic [31:0] raw_queue [$];
  reading_t    readings_due [$];
  logic        steady = 1'b0;
  int          mismatches = 0;
  int          accepted = 0;
  int          results = 0;
  int          faults = 0;
  int          cycles = 0;

  barometric_pressure_compensation_top u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] shift_ar(logic [31:0] v, int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] ext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic reading_t compensate(logic [15:0] ut, logic [15:0] up);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, dv, num, q;
    reading_t r;
    ac1 = ext16(coef[REG_AC1][15:0]);
    ac2 = ext16(coef[REG_AC2][15:0]);
    ac3 = ext16(coef[REG_AC3][15:0]);
    ac4 = {16'd0, coef[REG_AC4][15:0]};
    ac5 = {16'd0, coef[REG_AC5][15:0]};
    ac6 = {16'd0, coef[REG_AC6][15:0]};
    b1 = ext16(coef[REG_B1_B2][31:16]);
    b2 = ext16(coef[REG_B1_B2][15:0]);
    mc = ext16(coef[REG_MC_MD][31:16]);
    md = ext16(coef[REG_MC_MD][15:0]);
    r = '{temp: '0, press: '0, fault: 1'b1};
    x1 = ({16'd0, ut} - ac6) * ac5;
    x1 = shift_ar(x1, 15);
    dv = x1 + md;
    if (dv == 0) return r;
    num = mc << 11;
    q = (num[31] ? -num : num) / (dv[31] ? -dv : dv);
    x2 = (num[31] ^ dv[31]) ? -q : q;
    b5 = x1 + x2;
    r.temp = shift_ar(b5 + 32'd8, 4);
    b6 = b5 - 32'd4000;
    sq = shift_ar(b6 * b6, 12);
    x1 = shift_ar(b2 * sq, 11);
    x2 = shift_ar(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = shift_ar(ac1 * 32'd4 + x3 + 32'd2, 2);
    x1 = shift_ar(ac3 * b6, 13);
    x2 = shift_ar(b1 * sq, 16);
    x3 = shift_ar(x1 + x2 + 32'd2, 2);
    b4 = ac4 * (x3 + 32'd32768);
    b4 = b4 >> 15;
    if (b4 == 0) begin
      r.temp = '0;
      return r;
    end
    b7 = ({16'd0, up} - b3) * 32'd50000;
    if (!b7[31]) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = shift_ar(p, 8) * shift_ar(p, 8);
    x1 = shift_ar(x1 * 32'd3038, 16);
    x2 = shift_ar(NEG_7357 * p, 16);
    r.press = p + shift_ar(x1 + x2 + 32'd3791, 4);
    r.fault = 1'b0;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        readings_due.push_back(compensate(s_tdata[15:0], s_tdata[31:16]));
        accepted++;
      end
      if ((!s_tvalid || s_tready) ) begin
        if (raw_queue.size() > 0 && (steady || $urandom_range(99) >= 14)) begin
          s_tvalid <= 1'b1;
          s_tdata <= raw_queue.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reading_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** barometric_pressure_compensation_top: FAILED **");
      $finish;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results++;
        if (m_tuser) faults++;
        if (readings_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %h fault %b", m_tdata, m_tuser);
        end else begin
          want = readings_due.pop_front();
          if (m_tdata[31:0] !== want.temp || m_tdata[63:32] !== want.press ||
              m_tuser !== want.fault) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: temp %h/%h press %h/%h fault %b/%b (exp/act)",
                       want.temp, m_tdata[31:0], want.press, m_tdata[63:32],
                       want.fault, m_tuser);
          end
        end
      end
      m_tready <= steady || $urandom_range(99) >= 14;
    end
  end

  task automatic drain();
    while (raw_queue.size() > 0 || readings_due.size() > 0 || s_tvalid) @(posedge clk);
  endtask

  task automatic load_coefs(logic [31:0] vals [8]);
    drain();
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= 3'(i);
      cfg_data <= vals[i];
      coef[i] = (i < REG_B1_B2) ? {16'd0, vals[i][15:0]} : vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) raw_queue.push_back($urandom());
  endtask

  initial begin
    logic [31:0] vals [8];
    coef[REG_AC1] = {16'd0, RST_AC1};  coef[REG_AC2] = {16'd0, RST_AC2};
    coef[REG_AC3] = {16'd0, RST_AC3};  coef[REG_AC4] = {16'd0, RST_AC4};
    coef[REG_AC5] = {16'd0, RST_AC5};  coef[REG_AC6] = {16'd0, RST_AC6};
    coef[REG_B1_B2] = RST_B1_B2;
    coef[REG_MC_MD] = RST_MC_MD;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients, field extremes
    raw_queue = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_FFFF,
                  32'h7FFF_8000, 32'h8000_7FFF, {16'd23843, 16'd27898},
                  32'h5555_AAAA, 32'hAAAA_5555, 32'h0001_0001};
    drain();

    // temperature divisor zero: ac5 = 0, md = 0
    vals = '{32'd408, 32'hFFB8, 32'hC7D1, 32'd32741, 32'd0, 32'd23153,
             32'd405667844, 32'hDDF9_0000};
    load_coefs(vals);
    raw_queue = '{32'h0000_0000, 32'hFFFF_FFFF, {16'd23843, 16'd27898}};
    drain();

    // pressure divisor zero: ac4 = 0
    vals = '{32'd408, 32'hFFB8, 32'hC7D1, 32'd0, 32'd32757, 32'd23153,
             32'd405667844, 32'd3724086068};
    load_coefs(vals);
    raw_queue = '{32'h0000_0000, 32'hFFFF_FFFF, {16'd23843, 16'd27898}};
    drain();

    // coefficient extremes
    vals = '{32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF};
    load_coefs(vals); add_random(100); drain();
    vals = '{32'h8000, 32'h8000, 32'h8000, 32'hFFFF, 32'hFFFF, 32'h0,
             32'h8000_8000, 32'h8000_7FFF};
    load_coefs(vals); add_random(100); drain();
    vals = '{32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h1, 32'h1, 32'hFFFF,
             32'h7FFF_7FFF, 32'h7FFF_8000};
    load_coefs(vals); add_random(100); drain();

    // back to reset values, long run without gaps
    vals = '{32'd408, 32'hFFB8, 32'hC7D1, 32'd32741, 32'd32757, 32'd23153,
             32'd405667844, 32'd3724086068};
    load_coefs(vals);
    steady = 1'b1;
    add_random(300);
    drain();
    steady = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 8; i++) vals[i] = $urandom();
      load_coefs(vals);
      add_random(190);
      drain();
    end

    repeat (100) @(posedge clk);
    $display("%0d readings sent, %0d results checked (%0d with fault)", accepted, results,
             faults);
    $display("coefficient sets: reset, zero divisors, extremes, random");
    if (mismatches == 0 && readings_due.size() == 0)
      $display("** barometric_pressure_compensation_top: PASSED **");
    else
      $display("** barometric_pressure_compensation_top: FAILED **");
    $finish;
  end

endmodule
